[rtl/char_poly_faddeev_leverrier_top_macros.svh]
// Assertion macros for the characteristic polynomial block.
`ifndef CHAR_POLY_FADDEEV_LEVERRIER_TOP_MACROS_SVH
`define CHAR_POLY_FADDEEV_LEVERRIER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CPFL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CPFL_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CPFL_ASSERT(label, clk, rst, prop, msg)
`define CPFL_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[rtl/cpfl_pkg.sv]
// Package with types, constants and arithmetic helpers for the polynomial block.
`timescale 1ns / 1ps
package cpfl_pkg;
   localparam int MAX_ORDER  = 8;
   localparam int DEPTH      = MAX_ORDER * MAX_ORDER;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int IDX_W      = $clog2(MAX_ORDER);
   localparam int ORD_W      = 4;
   localparam int VAL_W      = 48;
   localparam int ELEM_W     = 32;
   localparam int RECIP_W    = 33;
   // Multiplier split: the wide operand is taken in two halves.
   localparam int HALF_W     = VAL_W / 2;
   localparam int NARROW_W   = RECIP_W + 1;
   localparam int PART_W     = HALF_W + 1 + NARROW_W;

   localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic signed [VAL_W-1:0] ONE_Q16 = VAL_W'(65536);

   typedef enum logic [3:0] {
      ST_LOAD, ST_INIT, ST_MAC_RD, ST_MAC, ST_MAC_HI, ST_MAC_WB, ST_TR_RD, ST_TR,
      ST_DIV, ST_DIV_HI, ST_DIV_WB, ST_UPD_RD, ST_UPD, ST_EMIT
   } state_type;

   // Saturation result: value and whether it clipped.
   typedef struct packed {
      logic signed [VAL_W-1:0] val;
      logic                    sat;
   } sat_type;

   // Reciprocal round(2^32/i) for i = 1..MAX_ORDER.
   function automatic logic [RECIP_W-1:0] recip(input logic [ORD_W-1:0] i);
      logic [RECIP_W-1:0] r;
      r = '0;
      for (int k = 1; k <= MAX_ORDER; k++)
         if (i == ORD_W'(k)) r = RECIP_W'(((64'd1 << 32) + 64'(k / 2)) / 64'(k));
      return r;
   endfunction

   // Saturating sum of two 48-bit values.
   function automatic sat_type sat_add(input logic signed [VAL_W-1:0] a,
                                       input logic signed [VAL_W-1:0] b);
      logic signed [VAL_W:0] s;
      sat_type o;
      s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      o.sat = s[VAL_W] != s[VAL_W-1];
      o.val = o.sat ? (s[VAL_W] ? VMIN : VMAX) : s[VAL_W-1:0];
      return o;
   endfunction

   // Round a signed product magnitude-wise by 2^-sh, ties away, saturate.
   function automatic sat_type round_sat(input logic signed [95:0] p, input logic neg32);
      logic        ng;
      logic [95:0] m;
      logic [95:0] r;
      sat_type     o;
      ng = p[95];
      m  = ng ? (96'd0 - 96'(p)) : 96'(p);
      r  = neg32 ? ((m + (96'd1 << 31)) >> 32) : ((m + (96'd1 << 15)) >> 16);
      if (ng) begin
         o.sat = r > (96'd1 << 47);
         o.val = o.sat ? VMIN : VAL_W'(96'd0 - r);
      end else begin
         o.sat = r > ((96'd1 << 47) - 96'd1);
         o.val = o.sat ? VMAX : VAL_W'(r);
      end
      return o;
   endfunction
endpackage

[rtl/cpfl_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module cpfl_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/cpfl_mac.sv]
// Multiply unit: split signed product over two halves, then rounding and saturation.
`timescale 1ns / 1ps
module cpfl_mac import cpfl_pkg::*; (
   input  logic                    clock,
   input  logic signed [VAL_W-1:0] op_a,
   input  logic signed [VAL_W-1:0] op_b,
   input  logic                    div_mode,
   input  logic                    high_half,
   output sat_type                 result
);
   logic signed [HALF_W:0]     half_a;
   logic signed [NARROW_W-1:0] narrow_b;
   logic signed [PART_W-1:0]   part;
   logic signed [PART_W-1:0]   lo_ff;
   logic signed [95:0]         prod_ff, prod_in;
   logic                       mode_ff;

   // One half of the wide operand times the narrow one. The low half goes first
   // and is held; the high half follows and is shifted and added to it.
   // The narrow operand fits in 34 signed bits in either mode.
   always_comb begin
      half_a   = high_half ? {op_a[VAL_W-1], op_a[VAL_W-1:HALF_W]}
                           : {1'b0, op_a[HALF_W-1:0]};
      narrow_b = op_b[NARROW_W-1:0];
      part     = half_a * narrow_b;
      prod_in  = (96'(part) <<< HALF_W) + 96'(lo_ff);
   end

   always_ff @(posedge clock) begin
      if (!high_half) lo_ff <= part;
      prod_ff <= prod_in;
      mode_ff <= div_mode;
   end

   // Rounding is combinational on the product register.
   always_comb result = round_sat(prod_ff, mode_ff);
endmodule

[rtl/char_poly_faddeev_leverrier_top.sv]
// Top level of the Faddeev-LeVerrier characteristic polynomial block.
`timescale 1ns / 1ps
`include "char_poly_faddeev_leverrier_top_macros.svh"
// The block takes n*n Q16.16 elements row-major, one per beat, then runs the
// recurrence on one multiplier over three RAMs (matrix, B, product) and emits
// n+1 Q32.16 coefficients, highest power first. The block is ready throughout loading.
// A run first writes the identity into B, then for each iteration forms the B*A
// products term by term (read, low-half multiply, high-half multiply and
// accumulate per term) on the single split multiplier behind the registered RAM
// reads, sums the trace of the product, divides it by the iteration number
// through a reciprocal multiply and, before the last iteration, updates B.
// Input is not taken during the run or while coefficients are being sent.
module char_poly_faddeev_leverrier_top import cpfl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [ORD_W-1:0]         csr_write_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [ELEM_W-1:0] req_elem_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [VAL_W-1:0]  rsp_coeff_value,
   output logic [ORD_W-1:0]         rsp_coeff_index,
   output logic                     rsp_last_coeff,
   output logic                     rsp_overflow_seen
);
   state_type state_ff, state_in;
   logic [ORD_W-1:0]  order_ff, order_in;
   logic [ADDR_W:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]  r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic [ORD_W-1:0]  iter_ff, iter_in;
   logic signed [VAL_W-1:0] acc_ff, acc_in, t_ff, t_in;
   logic              sat_ff, sat_in;
   logic signed [VAL_W-1:0] coef_ff [MAX_ORDER+1];
   logic              coef_we;
   logic signed [VAL_W-1:0] coef_wd;
   logic [ORD_W-1:0]  out_ff, out_in;
   logic [ORD_W-1:0]  n;
   logic [IDX_W-1:0]  nm1;

   logic              m_we, b_we, p_we;
   logic [ADDR_W-1:0] m_wa, b_wa, p_wa, m_ra, b_ra, p_ra;
   logic [ELEM_W-1:0] m_rd;
   logic [VAL_W-1:0]  b_wd, p_wd, b_rd, p_rd;
   logic signed [VAL_W-1:0] op_a, op_b;
   logic              div_mode;
   logic              mac_hi;
   sat_type           mres, s1;
   logic [ADDR_W-1:0] rc_addr, rr_addr, rk_addr, kc_addr;

   // Effective order, clamped to 1..MAX_ORDER.
   always_comb begin
      if (order_ff == '0) n = ORD_W'(1);
      else if (order_ff > ORD_W'(MAX_ORDER)) n = ORD_W'(MAX_ORDER);
      else n = order_ff;
      nm1 = IDX_W'(n - ORD_W'(1));
   end

   // Addresses of row r, column c / k in row-major layout.
   always_comb begin
      rc_addr = ADDR_W'(r_ff * n + ORD_W'(c_ff));
      rr_addr = ADDR_W'(r_ff * n + ORD_W'(r_ff));
      rk_addr = ADDR_W'(r_ff * n + ORD_W'(k_ff));
      kc_addr = ADDR_W'(k_ff * n + ORD_W'(c_ff));
   end

   cpfl_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_mat (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(req_elem_value),
      .rd_addr(m_ra), .rd_data(m_rd));
   cpfl_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_b (
      .clock(clock), .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd),
      .rd_addr(b_ra), .rd_data(b_rd));
   cpfl_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_p (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));

   cpfl_mac u_mac (.clock(clock), .op_a(op_a), .op_b(op_b), .div_mode(div_mode),
      .high_half(mac_hi), .result(mres));

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         order_ff <= ORD_W'(MAX_ORDER);
         cnt_ff   <= '0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         order_ff <= order_in;
         cnt_ff   <= cnt_in;
         sat_ff   <= sat_in;
      end
      r_ff <= r_in; c_ff <= c_in; k_ff <= k_in; iter_ff <= iter_in;
      acc_ff <= acc_in; t_ff <= t_in; out_ff <= out_in;
      if (coef_we) coef_ff[iter_ff] <= coef_wd;
   end

   // Sequencer: next state, RAM accesses and datapath control.
   always_comb begin
      state_in = state_ff; order_in = order_ff; cnt_in = cnt_ff; sat_in = sat_ff;
      r_in = r_ff; c_in = c_ff; k_in = k_ff; iter_in = iter_ff;
      acc_in = acc_ff; t_in = t_ff; out_in = out_ff;
      coef_we = 1'b0; coef_wd = '0;
      m_we = 1'b0; m_wa = ADDR_W'(cnt_ff); m_ra = kc_addr;
      b_we = 1'b0; b_wa = rc_addr; b_wd = '0; b_ra = rk_addr;
      p_we = 1'b0; p_wa = rc_addr; p_wd = acc_ff; p_ra = rr_addr;
      op_a = $signed(b_rd); op_b = VAL_W'($signed(m_rd)); div_mode = 1'b0;
      mac_hi = 1'b0;
      s1 = sat_add(acc_ff, mres.val);
      req_ready = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               m_we = 1'b1;
               if (cnt_in + 1'b1 >= (ADDR_W+1)'(n * n)) begin
                  cnt_in = '0; state_in = ST_INIT; sat_in = 1'b0;
                  r_in = '0; c_in = '0; iter_in = '0;
               end else cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_INIT: begin
            // Write the identity into B, one entry a cycle, and set c_0.
            b_we = 1'b1; b_wd = (r_ff == c_ff) ? ONE_Q16 : '0;
            coef_we = 1'b1;
            coef_wd = n[0] ? -ONE_Q16 : ONE_Q16;
            if (c_ff == nm1) begin
               c_in = '0;
               if (r_ff == nm1) begin
                  r_in = '0; k_in = '0; iter_in = ORD_W'(1); acc_in = '0;
                  state_in = ST_MAC_RD;
               end else r_in = r_ff + 1'b1;
            end else c_in = c_ff + 1'b1;
         end
         ST_MAC_RD: begin
            // Reads for term k issued; operands valid next cycle.
            state_in = ST_MAC;
         end
         ST_MAC: begin
            // Low half of the product.
            state_in = ST_MAC_HI;
         end
         ST_MAC_HI: begin
            // High half; the operands are still held by the RAM outputs.
            mac_hi = 1'b1; state_in = ST_MAC_WB;
         end
         ST_MAC_WB: begin
            // Product registered last cycle: accumulate.
            acc_in = s1.val; sat_in = sat_ff | s1.sat | mres.sat;
            if (k_ff == nm1) begin
               p_we = 1'b1; p_wd = s1.val; k_in = '0; acc_in = '0;
               state_in = ST_MAC_RD;
               if (c_ff == nm1) begin
                  c_in = '0;
                  if (r_ff == nm1) begin
                     r_in = '0; state_in = ST_TR_RD;
                  end else r_in = r_ff + 1'b1;
               end else c_in = c_ff + 1'b1;
            end else begin
               k_in = k_ff + 1'b1; state_in = ST_MAC_RD;
            end
         end
         ST_TR_RD: begin
            state_in = ST_TR;
         end
         ST_TR: begin
            s1 = sat_add(acc_ff, $signed(p_rd));
            acc_in = s1.val; sat_in = sat_ff | s1.sat;
            if (r_ff == nm1) begin
               r_in = '0; state_in = ST_DIV;
            end else begin
               r_in = r_ff + 1'b1; state_in = ST_TR_RD;
            end
         end
         ST_DIV: begin
            op_a = acc_ff; op_b = VAL_W'(recip(iter_ff)); div_mode = 1'b1;
            state_in = ST_DIV_HI;
         end
         ST_DIV_HI: begin
            op_a = acc_ff; op_b = VAL_W'(recip(iter_ff)); div_mode = 1'b1;
            mac_hi = 1'b1; state_in = ST_DIV_WB;
         end
         ST_DIV_WB: begin
            t_in = mres.val; sat_in = sat_ff | mres.sat;
            s1 = sat_add(VAL_W'(0), -mres.val);
            coef_we = 1'b1;
            if (n[0]) coef_wd = mres.val;
            else begin
               coef_wd = (mres.val == VMIN) ? VMAX : -mres.val;
               if (mres.val == VMIN) sat_in = 1'b1;
            end
            if (iter_ff == n) begin
               out_in = '0; state_in = ST_EMIT;
            end else begin
               r_in = '0; c_in = '0; state_in = ST_UPD_RD;
            end
         end
         ST_UPD_RD: begin
            p_ra = rc_addr; state_in = ST_UPD;
         end
         ST_UPD: begin
            // Copy P into B, subtracting t on the diagonal.
            b_we = 1'b1; b_wd = p_rd;
            if (r_ff == c_ff) begin
               s1 = sat_add($signed(p_rd), (t_ff == VMIN) ? VMAX : -t_ff);
               if (t_ff == VMIN) begin
                  // p - VMIN needs the full width; handle by sign.
                  s1.val = $signed(p_rd) >= 0 ? VMAX : $signed(p_rd) - VMIN;
                  s1.sat = $signed(p_rd) >= 0;
               end
               b_wd = s1.val; sat_in = sat_ff | s1.sat;
            end
            state_in = ST_UPD_RD;
            if (c_ff == nm1) begin
               c_in = '0;
               if (r_ff == nm1) begin
                  r_in = '0; k_in = '0; acc_in = '0;
                  iter_in = iter_ff + 1'b1; state_in = ST_MAC_RD;
               end else r_in = r_ff + 1'b1;
            end else c_in = c_ff + 1'b1;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (out_ff == n) state_in = ST_LOAD;
               else out_in = out_ff + 1'b1;
            end
         end
         default: state_in = ST_LOAD;
      endcase
      // A register write discards a partial load.
      if (csr_write_enable) begin
         order_in = csr_write_data; cnt_in = '0;
      end
   end

   // Result channel driven straight from the coefficient registers.
   assign rsp_valid         = state_ff == ST_EMIT;
   assign rsp_coeff_value   = coef_ff[out_ff];
   assign rsp_coeff_index   = out_ff;
   assign rsp_last_coeff    = out_ff == n;
   assign rsp_overflow_seen = sat_ff;

   `CPFL_ASSERT(a_no_accept_in_run, clock, reset, state_ff != ST_LOAD |-> !req_ready, "input taken during run")
   `CPFL_ASSERT(a_idx_range, clock, reset, rsp_valid |-> rsp_coeff_index <= n, "index beyond order")
   `CPFL_ASSERT(a_last_exit, clock, reset, rsp_valid && rsp_ready && rsp_last_coeff |=> state_ff == ST_LOAD, "emit did not end")
endmodule

[test/char_poly_faddeev_leverrier_top_tb.sv]
// Self-checking testbench for the Faddeev-LeVerrier characteristic polynomial block.
`timescale 1ns / 1ps
module char_poly_faddeev_leverrier_top_tb;
   import cpfl_pkg::*;

   // One expected coefficient beat.
   typedef struct {
      logic signed [VAL_W-1:0] value;
      logic [ORD_W-1:0]        index;
      logic                    last;
      logic                    ovf;
   } coeff_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_write_enable;
   logic [ORD_W-1:0]         csr_write_data;
   logic                     req_valid;
   logic                     req_ready;
   logic signed [ELEM_W-1:0] req_elem_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [VAL_W-1:0]  rsp_coeff_value;
   logic [ORD_W-1:0]         rsp_coeff_index;
   logic                     rsp_last_coeff;
   logic                     rsp_overflow_seen;

   // Predictor state.
   logic [ORD_W-1:0]   order_reg;
   int                 elems_loaded;
   logic signed [63:0] mat_a [DEPTH];
   logic signed [63:0] mat_b [DEPTH];
   logic signed [63:0] mat_p [DEPTH];
   logic               clipped;
   coeff_type          pending_coeffs[$];

   int  error_count;
   int  coeffs_checked;
   int  matrices_done;
   int  items_sent;
   bit  quiet;
   int  stall_left;

   char_poly_faddeev_leverrier_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_elem_value    (req_elem_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_coeff_value   (rsp_coeff_value),
      .rsp_coeff_index   (rsp_coeff_index),
      .rsp_last_coeff    (rsp_last_coeff),
      .rsp_overflow_seen (rsp_overflow_seen)
   );

   // Clock with a 20 ns period.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Clip a wide value to the signed 48-bit range and note any clipping.
   function automatic logic signed [63:0] clip48(input logic signed [63:0] v);
      if (v > 64'(VMAX)) begin
         clipped = 1'b1;
         return 64'(VMAX);
      end
      if (v < 64'(VMIN)) begin
         clipped = 1'b1;
         return 64'(VMIN);
      end
      return v;
   endfunction

   // Product scaled by 2^-s, rounded half away from zero, then clipped.
   function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                         input logic signed [63:0] b,
                                                         input int s);
      logic         neg;
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] p;
      logic [127:0] lim;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? 64'(-a) : 64'(a);
      mb  = (b < 0) ? 64'(-b) : 64'(b);
      p   = ({64'd0, ma} * {64'd0, mb} + (128'd1 << (s - 1))) >> s;
      lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 128'd1);
      if (p > lim) begin
         clipped = 1'b1;
         return neg ? 64'(VMIN) : 64'(VMAX);
      end
      return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
   endfunction

   // Accept one element; on the last one, run the recurrence and queue the coefficients.
   task automatic absorb_element(input logic signed [ELEM_W-1:0] v);
      int n;
      int total;
      logic signed [63:0] acc;
      logic signed [63:0] tr;
      logic signed [63:0] t;
      logic signed [63:0] rcp;
      logic signed [63:0] coef [MAX_ORDER+1];
      coeff_type e;
      n = (order_reg == 0) ? 1 : ((order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg));
      total = n * n;
      if (elems_loaded >= total) elems_loaded = 0;
      mat_a[elems_loaded] = 64'(v);
      elems_loaded++;
      if (elems_loaded < total) return;
      elems_loaded = 0;
      clipped = 1'b0;
      for (int k = 0; k < total; k++)
         mat_b[k] = ((k / n) == (k % n)) ? 64'sd65536 : 64'sd0;
      coef[0] = (n % 2) ? -64'sd65536 : 64'sd65536;
      for (int i = 1; i <= n; i++) begin
         for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
               acc = 0;
               for (int k = 0; k < n; k++)
                  acc = clip48(acc + scaled_product(mat_b[r*n+k], mat_a[k*n+c], 16));
               mat_p[r*n+c] = acc;
            end
         tr = 0;
         for (int r = 0; r < n; r++)
            tr = clip48(tr + mat_p[r*n+r]);
         rcp = ((64'sd1 <<< 32) + i / 2) / i;
         t = scaled_product(tr, rcp, 32);
         coef[i] = (n % 2) ? t : clip48(-t);
         if (i < n) begin
            for (int k = 0; k < total; k++) mat_b[k] = mat_p[k];
            for (int r = 0; r < n; r++)
               mat_b[r*n+r] = clip48(mat_p[r*n+r] - t);
         end
      end
      for (int i = 0; i <= n; i++) begin
         e.value = coef[i][VAL_W-1:0];
         e.index = ORD_W'(i);
         e.last  = (i == n);
         e.ovf   = clipped;
         pending_coeffs.push_back(e);
      end
      matrices_done++;
   endtask

   // Send one element beat, with an optional idle burst first.
   task automatic send_element(input logic signed [ELEM_W-1:0] v);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_elem_value <= v;
      do @(posedge clock); while (!req_ready);
      absorb_element(v);
      items_sent++;
   endtask

   // Lower valid, drain all coefficients, let the block settle, then write the order.
   task automatic set_order(input logic [ORD_W-1:0] ord);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_coeffs.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= ord;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      order_reg    = ord;
      elems_loaded = 0;
   endtask

   // Random element: mostly small values, sometimes full range.
   function automatic logic signed [ELEM_W-1:0] rand_element();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return $signed(ELEM_W'($urandom_range(0, 32'h40000))) - 32'sh20000;
   endfunction

   task automatic send_matrix(input int n);
      for (int k = 0; k < n * n; k++) send_element(rand_element());
   endtask

   // Order one: the extremes of the element field, and order zero acting as one.
   task automatic test_order_one();
      set_order(4'd1);
      send_element(32'sh7FFFFFFF);
      send_element(-32'sh80000000);
      set_order(4'd0);
      send_element(32'sh00010000);
   endtask

   // Order two: identity, then a diagonal.
   task automatic test_identity();
      set_order(4'd2);
      send_element(32'sh10000);
      send_element(32'sh0);
      send_element(32'sh0);
      send_element(32'sh10000);
      send_element(32'sh30000);
      send_element(32'sh0);
      send_element(32'sh0);
      send_element(-32'sh18000);
   endtask

   // Full-range order-three matrix drives the working values into saturation.
   task automatic test_saturation();
      set_order(4'd3);
      for (int k = 0; k < 9; k++) send_element($urandom | 32'h40000000);
   endtask

   // A partial load followed by a register write must be thrown away.
   task automatic test_partial_discard();
      set_order(4'd2);
      send_element(32'sh7FFF0000);
      send_element(32'sh12345);
      set_order(4'd1);
      send_element(32'sh00028000);
   endtask

   // Random orders, including out-of-range ones, with occasional broken loads.
   task automatic test_random_matrices();
      int pick;
      int n;
      logic [ORD_W-1:0] ord;
      while (items_sent < 120) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) ord = 4'd0;
         else if (pick == 1) ord = ORD_W'($urandom_range(9, 15));
         else if (pick <= 3) ord = ORD_W'($urandom_range(5, 8));
         else ord = ORD_W'($urandom_range(1, 4));
         n = (ord == 0) ? 1 : ((ord > MAX_ORDER) ? MAX_ORDER : int'(ord));
         set_order(ord);
         if (n > 1 && $urandom_range(0, 5) == 0) begin
            for (int k = 0; k < $urandom_range(1, n * n - 1); k++)
               send_element(rand_element());
            set_order(ord);
         end
         repeat ((n <= 4) ? $urandom_range(1, 3) : 1) send_matrix(n);
      end
   endtask

   // Back-to-back traffic with no idling on either side.
   task automatic test_full_rate();
      quiet = 1'b1;
      set_order(4'd3);
      repeat (2) send_matrix(3);
      set_order(4'd8);
      send_matrix(8);
   endtask

   // Result side: random stall bursts, none once quiet is set.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each coefficient beat with the oldest expectation.
   always @(posedge clock) begin
      coeff_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_coeffs.size() == 0) begin
            $display("%0t: unexpected coefficient beat value=%0d index=%0d",
                     $time, rsp_coeff_value, rsp_coeff_index);
            error_count++;
         end else begin
            e = pending_coeffs.pop_front();
            coeffs_checked++;
            if (rsp_coeff_value !== e.value) begin
               $display("%0t: coeff_value expected %0d actual %0d", $time, e.value,
                        rsp_coeff_value);
               error_count++;
            end
            if (rsp_coeff_index !== e.index) begin
               $display("%0t: coeff_index expected %0d actual %0d", $time, e.index,
                        rsp_coeff_index);
               error_count++;
            end
            if (rsp_last_coeff !== e.last) begin
               $display("%0t: last_coeff expected %0b actual %0b", $time, e.last,
                        rsp_last_coeff);
               error_count++;
            end
            if (rsp_overflow_seen !== e.ovf) begin
               $display("%0t: overflow_seen expected %0b actual %0b", $time, e.ovf,
                        rsp_overflow_seen);
               error_count++;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_elem_value   = '0;
      order_reg        = 4'd8;
      elems_loaded     = 0;
      clipped          = 1'b0;
      error_count      = 0;
      coeffs_checked   = 0;
      matrices_done    = 0;
      items_sent       = 0;
      quiet            = 1'b0;
      stall_left       = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_order_one();
      test_identity();
      test_saturation();
      test_partial_discard();
      test_random_matrices();
      test_full_rate();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_coeffs.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Sent %0d elements over %0d matrices of orders 1 to 8.", items_sent,
               matrices_done);
      $display("Checked %0d coefficients, %0d mismatches.", coeffs_checked, error_count);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog.
   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
